// File: rtl/csk_pkg.sv
// Shared constants for the cubic-spline SPH kernel pipeline.
// Holds fixed-point formats, stage counts and register indexes; no dependencies.
package csk_pkg;

  // Fractional bits of every fixed-point value.
  localparam int FRAC = 16;
  // Width of q, P and the unit-vector quotient (values up to one).
  localparam int QW = FRAC + 1;
  // Width of the derivative term M (up to six).
  localparam int MW = FRAC + 3;
  // Width of c = k * M after the fractional shift.
  localparam int CW = 32 + MW - FRAC;
  // Width of the reassembled a * u product.
  localparam int PW = 64 + QW + 1;

  // Square root: one result bit per stage.
  localparam int SQ_STEPS = 32;
  // Unit-vector division: one quotient bit per stage.
  localparam int DIV_STEPS = FRAC + 1;
  // Delay that lines the kernel path up with the division.
  localparam int POLY_DLY = DIV_STEPS - 4;
  // Cycles from an accepted word to its result strobe.
  localparam int LATENCY = SQ_STEPS + DIV_STEPS + 6;

  localparam logic [QW-1:0] ONE = QW'(1) << FRAC;
  localparam logic [QW-1:0] HALF = QW'(1) << (FRAC - 1);

  // Gradient clamp bounds.
  localparam logic [47:0] G_POS_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] G_NEG_MAG = 48'h8000_0000_0000;

  // Register indexes.
  localparam logic [1:0] CFG_INV_H = 2'd0;
  localparam logic [1:0] CFG_KSCALE = 2'd1;
  localparam logic [1:0] CFG_3D = 2'd2;

  // Register reset values.
  localparam logic [31:0] RST_INV_H = 32'd65536;
  localparam logic [31:0] RST_KSCALE = 32'd65536;

endpackage

// File: rtl/cubic_spline_sph_kernel.sv
// Top level of the cubic-spline SPH kernel and gradient pipeline.
// Depends on csk_pkg for formats, stage counts and register indexes.
//
// Usage:
//   A displacement word (in_disp_x/y/z, signed Q16.16) is taken at each rising
//   edge where start is high and busy is low. busy is always low: a new word
//   may enter in every cycle, one result per cycle sustained.
//   Each result (kernel value, gradient, support flag) appears on the out_
//   ports for one cycle with out_valid high. Between input and output lie
//   the 32-stage square root and the 17-stage unit-vector divider, one bit
//   per stage, plus six more stages: magnitude, square, sum, division
//   entry, gradient multiply and output.
//   Results leave in input order; the receiver cannot stall, so nothing ever
//   backs up into the pipeline.
//   Registers (1/h, k, 3D select) are written through cfg_we, cfg_index and
//   cfg_wdata, one write per cycle; the user must write them only while no
//   word is in flight (the block does not enforce this). A synchronous low
//   rst_n empties the pipeline and restores 1/h = 1.0, k = 1.0 and 3D mode.
module cubic_spline_sph_kernel (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_disp_x,
  input  logic signed [31:0] in_disp_y,
  input  logic signed [31:0] in_disp_z,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  output logic               out_valid,
  output logic [31:0]        out_kernel_value,
  output logic signed [47:0] out_grad_x,
  output logic signed [47:0] out_grad_y,
  output logic signed [47:0] out_grad_z,
  output logic               out_inside_support
);

  localparam int FRAC = csk_pkg::FRAC;
  localparam int QW = csk_pkg::QW;
  localparam int MW = csk_pkg::MW;
  localparam int CW = csk_pkg::CW;
  localparam int PW = csk_pkg::PW;
  localparam int SQ = csk_pkg::SQ_STEPS;
  localparam int DIV = csk_pkg::DIV_STEPS;
  localparam int DLY = csk_pkg::POLY_DLY;
  localparam int LAT = csk_pkg::LATENCY;
  localparam int Q2 = 2 * QW;

  // Configuration registers.
  logic [31:0] inv_h_r;
  logic [31:0] kscale_r;
  logic        three_d_r;

  // Front stages: magnitudes, squares.
  logic        a_v_r;
  logic [31:0] a_mag_r [0:2];
  logic [2:0]  a_neg_r;
  logic        b_v_r;
  logic [63:0] b_sq_r [0:2];
  logic [31:0] b_mag_r [0:2];
  logic [2:0]  b_neg_r;

  // Square-root stages.
  logic [SQ:0] sq_v_r;
  logic [63:0] sq_rad_r [0:SQ];
  logic [33:0] sq_rem_r [0:SQ];
  logic [31:0] sq_root_r [0:SQ];
  logic [31:0] sq_mag_r [0:SQ][0:2];
  logic [2:0]  sq_neg_r [0:SQ];
  logic [35:0] sq_shr [0:SQ-1];
  logic [35:0] sq_trial [0:SQ-1];
  logic [33:0] sq_rem_nxt [0:SQ-1];
  logic [31:0] sq_root_nxt [0:SQ-1];

  // Division stages for the unit vector.
  logic [DIV:0]    d_v_r;
  logic [31:0]     d_rem_r [0:DIV][0:2];
  logic [QW-1:0]   d_quo_r [0:DIV][0:2];
  logic [2:0]      d_bit_r [0:DIV];
  logic [31:0]     d_r_r [0:DIV];
  logic [2:0]      d_neg_r [0:DIV];
  logic [32:0]     d_t [0:DIV-1][0:2];
  logic [31:0]     d_rem_nxt [0:DIV-1][0:2];
  logic [QW-1:0]   d_quo_nxt [0:DIV-1][0:2];

  // Kernel polynomial stages.
  logic [63:0]     p1_prod_r;
  logic [63:0]     p2_qfull;
  logic [QW-1:0]   p2_q_nxt;
  logic [QW-1:0]   p2_f_nxt;
  logic [QW-1:0]   p2_sqin;
  logic [Q2-1:0]   p2_sfull;
  logic            p2_inner_nxt;
  logic            p2_out_nxt;
  logic [QW-1:0]   p2_q_r;
  logic [QW-1:0]   p2_f_r;
  logic [QW-1:0]   p2_s_r;
  logic            p2_inner_r;
  logic            p2_out_r;
  logic [Q2-1:0]   p3_tfull;
  logic [MW-1:0]   p3_m_nxt;
  logic [QW-1:0]   p3_t_r;
  logic [MW-1:0]   p3_m_r;
  logic            p3_inner_r;
  logic            p3_out_r;
  logic [QW+2:0]   p4_six_t;
  logic [QW-1:0]   p4_p;
  logic [31+QW:0]  p4_wfull;
  logic [31+MW:0]  p4_cfull;
  logic [31:0]     p4_w_r;
  logic [CW-1:0]   p4_c_r;
  logic            p4_out_r;
  logic [CW+31:0]  p5_afull_r;
  logic [31:0]     p5_w_r;
  logic            p5_out_r;
  logic [63:0]     dl_a_r [0:DLY-1];
  logic [31:0]     dl_w_r [0:DLY-1];
  logic            dl_out_r [0:DLY-1];

  // Gradient multiply and output stages.
  logic            m_v_r;
  logic [31+QW:0]  m_plo_r [0:2];
  logic [31+QW:0]  m_phi_r [0:2];
  logic [2:0]      m_neg_r;
  logic [31:0]     m_w_r;
  logic            m_out_r;
  logic            m_rz_r;
  logic [PW-1:0]   g_full [0:2];
  logic [PW-1:0]   g_shift [0:2];
  logic [47:0]     g_lim [0:2];
  logic [47:0]     g_mag [0:2];
  logic [47:0]     g_nxt [0:2];
  logic            out_v_r;
  logic [31:0]     out_w_r;
  logic [47:0]     out_g_r [0:2];
  logic            out_in_r;

  logic        accept;
  logic [31:0] raw [0:2];
  logic [31:0] mag_nxt [0:2];

  assign busy = 1'b0;
  assign accept = start && !busy;

  // Configuration writes; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_h_r <= csk_pkg::RST_INV_H;
      kscale_r <= csk_pkg::RST_KSCALE;
      three_d_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        csk_pkg::CFG_INV_H:  inv_h_r <= cfg_wdata;
        csk_pkg::CFG_KSCALE: kscale_r <= cfg_wdata;
        csk_pkg::CFG_3D:     three_d_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Valid bits travel alongside the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      sq_v_r <= '0;
      d_v_r <= '0;
      m_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      a_v_r <= accept;
      b_v_r <= a_v_r;
      sq_v_r <= {sq_v_r[SQ-1:0], b_v_r};
      d_v_r <= {d_v_r[DIV-1:0], sq_v_r[SQ]};
      m_v_r <= d_v_r[DIV];
      out_v_r <= m_v_r;
    end
  end

  // Component magnitudes; z is dropped in 2D.
  always_comb begin
    raw[0] = in_disp_x;
    raw[1] = in_disp_y;
    raw[2] = in_disp_z;
    for (int i = 0; i < 3; i++) begin
      mag_nxt[i] = raw[i][31] ? (~raw[i] + 32'd1) : raw[i];
    end
    if (!three_d_r) begin
      mag_nxt[2] = 32'd0;
    end
  end

  // One root bit per stage: shift in two radicand bits, try to subtract.
  always_comb begin
    for (int j = 0; j < SQ; j++) begin
      sq_shr[j] = {sq_rem_r[j], sq_rad_r[j][63:62]};
      sq_trial[j] = {2'b00, sq_root_r[j], 2'b01};
      if (sq_shr[j] >= sq_trial[j]) begin
        sq_rem_nxt[j] = 34'(sq_shr[j] - sq_trial[j]);
        sq_root_nxt[j] = {sq_root_r[j][30:0], 1'b1};
      end else begin
        sq_rem_nxt[j] = sq_shr[j][33:0];
        sq_root_nxt[j] = {sq_root_r[j][30:0], 1'b0};
      end
    end
  end

  // One quotient bit per stage of |d_i| * 2^FRAC / r.
  always_comb begin
    for (int j = 0; j < DIV; j++) begin
      for (int i = 0; i < 3; i++) begin
        d_t[j][i] = {d_rem_r[j][i], d_bit_r[j][i]};
        if (d_t[j][i] >= {1'b0, d_r_r[j]}) begin
          d_rem_nxt[j][i] = 32'(d_t[j][i] - {1'b0, d_r_r[j]});
          d_quo_nxt[j][i] = {d_quo_r[j][i][QW-2:0], 1'b1};
        end else begin
          d_rem_nxt[j][i] = d_t[j][i][31:0];
          d_quo_nxt[j][i] = {d_quo_r[j][i][QW-2:0], 1'b0};
        end
      end
    end
  end

  // Kernel path: q, the square of q or 1 - q, the cubic term, P, M and their scaling by k.
  always_comb begin
    p2_qfull = p1_prod_r >> FRAC;
    p2_out_nxt = p2_qfull > {{(64 - QW){1'b0}}, csk_pkg::ONE};
    p2_q_nxt = p1_prod_r[FRAC+QW-1:FRAC];
    p2_inner_nxt = p2_q_nxt <= csk_pkg::HALF;
    p2_f_nxt = csk_pkg::ONE - p2_q_nxt;
    p2_sqin = p2_inner_nxt ? p2_q_nxt : p2_f_nxt;
    p2_sfull = Q2'(p2_sqin) * Q2'(p2_sqin);

    p3_tfull = Q2'(p2_s_r) * Q2'(p2_f_r);
    if (p2_inner_r) begin
      p3_m_nxt = MW'(p2_q_r) * MW'(12) - MW'(p2_s_r) * MW'(18);
    end else begin
      p3_m_nxt = MW'(p2_s_r) * MW'(6);
    end

    p4_six_t = (QW + 3)'(p3_t_r) * (QW + 3)'(6);
    if (p3_inner_r) begin
      p4_p = QW'((QW + 3)'(csk_pkg::ONE) - p4_six_t);
    end else begin
      p4_p = {p3_t_r[QW-2:0], 1'b0};
    end
    p4_wfull = (32 + QW)'(kscale_r) * (32 + QW)'(p4_p);
    p4_cfull = (32 + MW)'(kscale_r) * (32 + MW)'(p3_m_r);
  end

  // Gradient: reassemble a * u, clamp, sign opposite to d; zero if outside or r = 0.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      g_full[i] = {1'b0, m_phi_r[i], 32'd0} + {{(PW - 32 - QW){1'b0}}, m_plo_r[i]};
      g_shift[i] = g_full[i] >> FRAC;
      g_lim[i] = m_neg_r[i] ? csk_pkg::G_POS_MAX : csk_pkg::G_NEG_MAG;
      if (g_shift[i] > {{(PW - 48){1'b0}}, g_lim[i]}) begin
        g_mag[i] = g_lim[i];
      end else begin
        g_mag[i] = g_shift[i][47:0];
      end
      if (m_out_r || m_rz_r) begin
        g_nxt[i] = 48'd0;
      end else if (m_neg_r[i]) begin
        g_nxt[i] = g_mag[i];
      end else begin
        g_nxt[i] = ~g_mag[i] + 48'd1;
      end
    end
  end

  // Payload registers load every cycle; the valid bits say which hold a word.
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      a_mag_r[i] <= mag_nxt[i];
      b_mag_r[i] <= a_mag_r[i];
      b_sq_r[i] <= 64'(a_mag_r[i]) * 64'(a_mag_r[i]);
    end
    a_neg_r <= {raw[2][31], raw[1][31], raw[0][31]};
    b_neg_r <= a_neg_r;

    // Square-root entry and stages.
    sq_rad_r[0] <= b_sq_r[0] + b_sq_r[1] + b_sq_r[2];
    sq_rem_r[0] <= 34'd0;
    sq_root_r[0] <= 32'd0;
    sq_neg_r[0] <= b_neg_r;
    for (int i = 0; i < 3; i++) begin
      sq_mag_r[0][i] <= b_mag_r[i];
    end
    for (int j = 0; j < SQ; j++) begin
      sq_rad_r[j+1] <= {sq_rad_r[j][61:0], 2'b00};
      sq_rem_r[j+1] <= sq_rem_nxt[j];
      sq_root_r[j+1] <= sq_root_nxt[j];
      sq_neg_r[j+1] <= sq_neg_r[j];
      for (int i = 0; i < 3; i++) begin
        sq_mag_r[j+1][i] <= sq_mag_r[j][i];
      end
    end

    // Division entry: the top quotient bits are known zero since |d_i| <= r.
    d_r_r[0] <= sq_root_r[SQ];
    d_neg_r[0] <= sq_neg_r[SQ];
    for (int i = 0; i < 3; i++) begin
      d_rem_r[0][i] <= {1'b0, sq_mag_r[SQ][i][31:1]};
      d_bit_r[0][i] <= sq_mag_r[SQ][i][0];
      d_quo_r[0][i] <= '0;
    end
    for (int j = 0; j < DIV; j++) begin
      d_r_r[j+1] <= d_r_r[j];
      d_neg_r[j+1] <= d_neg_r[j];
      d_bit_r[j+1] <= 3'b000;
      for (int i = 0; i < 3; i++) begin
        d_rem_r[j+1][i] <= d_rem_nxt[j][i];
        d_quo_r[j+1][i] <= d_quo_nxt[j][i];
      end
    end

    // Kernel path registers.
    p1_prod_r <= 64'(sq_root_r[SQ]) * 64'(inv_h_r);
    p2_q_r <= p2_q_nxt;
    p2_f_r <= p2_f_nxt;
    p2_s_r <= p2_sfull[FRAC+QW-1:FRAC];
    p2_inner_r <= p2_inner_nxt;
    p2_out_r <= p2_out_nxt;
    p3_t_r <= p3_tfull[FRAC+QW-1:FRAC];
    p3_m_r <= p3_m_nxt;
    p3_inner_r <= p2_inner_r;
    p3_out_r <= p2_out_r;
    p4_w_r <= p4_wfull[FRAC+31:FRAC];
    p4_c_r <= p4_cfull[31+MW:FRAC];
    p4_out_r <= p3_out_r;
    p5_afull_r <= (CW + 32)'(p4_c_r) * (CW + 32)'(inv_h_r);
    p5_w_r <= p4_w_r;
    p5_out_r <= p4_out_r;
    dl_a_r[0] <= (|p5_afull_r[CW+31:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : p5_afull_r[63:0];
    dl_w_r[0] <= p5_w_r;
    dl_out_r[0] <= p5_out_r;
    for (int k = 1; k < DLY; k++) begin
      dl_a_r[k] <= dl_a_r[k-1];
      dl_w_r[k] <= dl_w_r[k-1];
      dl_out_r[k] <= dl_out_r[k-1];
    end

    // Gradient partial products, a split into two 32-bit halves.
    for (int i = 0; i < 3; i++) begin
      m_plo_r[i] <= (32 + QW)'(dl_a_r[DLY-1][31:0]) * (32 + QW)'(d_quo_r[DIV][i]);
      m_phi_r[i] <= (32 + QW)'(dl_a_r[DLY-1][63:32]) * (32 + QW)'(d_quo_r[DIV][i]);
    end
    m_neg_r <= d_neg_r[DIV];
    m_w_r <= dl_w_r[DLY-1];
    m_out_r <= dl_out_r[DLY-1];
    m_rz_r <= d_r_r[DIV] == 32'd0;

    // Output word.
    out_w_r <= m_out_r ? 32'd0 : m_w_r;
    out_in_r <= !m_out_r;
    for (int i = 0; i < 3; i++) begin
      out_g_r[i] <= g_nxt[i];
    end
  end

  assign out_valid = out_v_r;
  assign out_kernel_value = out_w_r;
  assign out_grad_x = out_g_r[0];
  assign out_grad_y = out_g_r[1];
  assign out_grad_z = out_g_r[2];
  assign out_inside_support = out_in_r;

`ifndef SYNTH
  // Past support the whole word must be zero.
  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_inside_support || (out_kernel_value == 32'd0 &&
      out_grad_x == 48'sd0 && out_grad_y == 48'sd0 && out_grad_z == 48'sd0)))
    else $error("nonzero result outside support");

  // Every accepted word yields a strobe after the fixed latency.
  a_latency_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(LAT) out_valid)
    else $error("result strobe missing");

  // No strobe without a word accepted the same latency earlier.
  a_latency_none: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##(LAT) !out_valid)
    else $error("unexpected result strobe");
`endif

endmodule

// File: verif/cubic_spline_sph_kernel_checker.sv
// Checker for the cubic-spline SPH kernel: predicts each result word from the accepted
// displacement word and compares it with the block's output. Depends on csk_pkg.
module cubic_spline_sph_kernel_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] in_disp_x,
  input  logic signed [31:0] in_disp_y,
  input  logic signed [31:0] in_disp_z,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               out_valid,
  input  logic [31:0]        out_kernel_value,
  input  logic signed [47:0] out_grad_x,
  input  logic signed [47:0] out_grad_y,
  input  logic signed [47:0] out_grad_z,
  input  logic               out_inside_support,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] kval;
    logic [47:0] gx;
    logic [47:0] gy;
    logic [47:0] gz;
    logic        in_sup;
  } kernel_word_t;

  localparam logic [63:0] FX1 = 64'd1 << 16;
  localparam logic [63:0] FXH = 64'd1 << 15;

  kernel_word_t kernel_q[$];
  logic [31:0] inv_h_copy;
  logic [31:0] kscale_copy;
  logic        dim3_copy;

  // Floor square root of a 64-bit value, two bits at a time.
  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] pw;
    res = 0;
    pw = 64'd1 << 62;
    while (pw > v) pw = pw >> 2;
    while (pw != 0) begin
      if (v >= res + pw) begin
        v = v - (res + pw);
        res = (res >> 1) + pw;
      end else begin
        res = res >> 1;
      end
      pw = pw >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] abs32(logic [31:0] x);
    if (x[31]) return 64'h1_0000_0000 - {32'd0, x};
    return {32'd0, x};
  endfunction

  // One gradient component: unit-vector share of a, signed opposite to d, clamped.
  function automatic logic [47:0] grad_comp(logic [31:0] raw, logic [63:0] mag,
                                             logic [63:0] r, logic [63:0] a);
    logic [63:0] u, hi, lo, g, lim, neg_g;
    if (mag == 0) return 48'd0;
    u = (mag << 16) / r;
    hi = a >> 16;
    lo = a & (FX1 - 1);
    lim = raw[31] ? (64'd1 << 47) - 1 : (64'd1 << 47);
    if (u != 0 && hi > (64'd1 << 48) / u) g = lim;
    else g = hi * u + ((lo * u) >> 16);
    if (g > lim) g = lim;
    neg_g = (64'd1 << 48) - g;
    return raw[31] ? g[47:0] : neg_g[47:0];
  endfunction

  function automatic kernel_word_t predict_kernel(logic [31:0] dx, logic [31:0] dy,
                                                  logic [31:0] dz);
    kernel_word_t w;
    logic [63:0]  mx, my, mz, ih, k, r, q, q2, t, f, f2, p, m, c, a;
    logic [127:0] prod;
    mx = abs32(dx);
    my = abs32(dy);
    mz = dim3_copy ? abs32(dz) : 64'd0;
    ih = {32'd0, inv_h_copy};
    k = {32'd0, kscale_copy};
    r = floor_root(mx * mx + my * my + mz * mz);
    w = '0;
    prod = 128'(r) * 128'(ih);
    if (prod[127:64] != 0) return w;
    q = prod[63:0] >> 16;
    if (q > FX1) return w;
    if (q <= FXH) begin
      q2 = (q * q) >> 16;
      t = (q2 * (FX1 - q)) >> 16;
      p = FX1 - 6 * t;
      m = 12 * q - 18 * q2;
    end else begin
      f = FX1 - q;
      f2 = (f * f) >> 16;
      p = 2 * ((f2 * f) >> 16);
      m = 6 * f2;
    end
    w.kval = 32'((k * p) >> 16);
    w.in_sup = 1'b1;
    // Zero distance keeps the kernel value but has no direction.
    if (r == 0) return w;
    c = (k * m) >> 16;
    prod = 128'(c) * 128'(ih);
    a = (prod[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : prod[63:0];
    w.gx = grad_comp(dx, mx, r, a);
    w.gy = grad_comp(dy, my, r, a);
    w.gz = dim3_copy ? grad_comp(dz, mz, r, a) : 48'd0;
    return w;
  endfunction

  assign pending = kernel_q.size();

  // Track registers, queue predictions for accepted words, check result words.
  always @(posedge clk) begin
    kernel_word_t exp_w;
    kernel_word_t got_w;
    if (!rst_n) begin
      inv_h_copy <= csk_pkg::RST_INV_H;
      kscale_copy <= csk_pkg::RST_KSCALE;
      dim3_copy <= 1'b1;
      kernel_q.delete();
    end else begin
      if (start && !busy)
        kernel_q.push_back(predict_kernel(in_disp_x, in_disp_y, in_disp_z));
      if (cfg_we) begin
        case (cfg_index)
          csk_pkg::CFG_INV_H: inv_h_copy <= cfg_wdata;
          csk_pkg::CFG_KSCALE: kscale_copy <= cfg_wdata;
          csk_pkg::CFG_3D: dim3_copy <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_valid) begin
        got_w = {out_kernel_value, out_grad_x, out_grad_y, out_grad_z,
                 out_inside_support};
        if (kernel_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result word %h", got_w);
        end else begin
          exp_w = kernel_q.pop_front();
          if (exp_w !== got_w) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display({"result mismatch: W %h/%h gx %h/%h gy %h/%h gz %h/%h",
                        " in %b/%b (exp/got)"},
                       exp_w.kval, got_w.kval, exp_w.gx, got_w.gx, exp_w.gy, got_w.gy,
                       exp_w.gz, got_w.gz, exp_w.in_sup, got_w.in_sup);
          end
        end
      end
    end
  end

  initial fail_count = 0;

endmodule

// File: verif/cubic_spline_sph_kernel_test.sv
// Testbench top for the cubic-spline SPH kernel: drives displacement and register words
// and gives the verdict. Depends on csk_pkg, the block and cubic_spline_sph_kernel_checker.
module cubic_spline_sph_kernel_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [31:0] in_disp_x, in_disp_y, in_disp_z;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [31:0]        cfg_wdata;
  logic               out_valid;
  logic [31:0]        out_kernel_value;
  logic signed [47:0] out_grad_x, out_grad_y, out_grad_z;
  logic               out_inside_support;
  int                 fail_count;
  int                 pending;
  int                 idle_pct;
  int                 quiet_cycles;

  cubic_spline_sph_kernel u_dut (.*);
  cubic_spline_sph_kernel_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Watchdog: cycles in which no word moves on either channel.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Send one displacement word, with random idle cycles in front of it.
  task automatic send_disp(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_disp_x <= x;
    in_disp_y <= y;
    in_disp_z <= z;
    do @(posedge clk); while (busy);
  endtask

  // Wait until the pipeline has drained, then write one register.
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (csk_pkg::LATENCY + 4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_comp(logic [31:0] lim);
    logic [31:0] m;
    m = $urandom_range(lim, 0);
    return $urandom_range(1) ? -m : m;
  endfunction

  // Random words: most scaled to the support radius, the rest raw bits at random scale.
  task automatic random_words(int n, logic [31:0] inv_h);
    logic [63:0] rad;
    logic [31:0] lim;
    for (int i = 0; i < n; i++) begin
      idle_pct = (i % 200 < 50) ? 0 : (i % 200 < 120) ? 88 : 24;
      rad = (inv_h == 0) ? 64'hFFFF_FFFF : (64'd1 << 32) / inv_h;
      lim = (rad > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : rad[31:0];
      if ($urandom_range(99) < 70)
        send_disp(rand_comp(lim), rand_comp(lim), rand_comp(lim));
      else
        send_disp($urandom >> $urandom_range(31), $urandom >> $urandom_range(31),
                  $urandom >> $urandom_range(31));
    end
  endtask

  task automatic directed_words();
    send_disp(0, 0, 0);
    send_disp(32'h8000_0000, 0, 0);
    send_disp(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_disp(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_disp(32768, 0, 0);
    send_disp(0, -32768, 0);
    send_disp(0, 0, 65536);
    send_disp(65536, 0, 0);
    send_disp(65537, 0, 0);
    send_disp(-1, 1, -1);
    send_disp(20000, -30000, 40000);
    send_disp(0, 0, 32'h8000_0000);
    send_disp(-45000, 12000, -9000);
  endtask

  initial begin
    logic [31:0] ih;
    rst_n = 0;
    start = 0;
    in_disp_x = 0;
    in_disp_y = 0;
    in_disp_z = 0;
    cfg_we = 0;
    cfg_index = csk_pkg::CFG_INV_H;
    cfg_wdata = 0;
    idle_pct = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings, then a pause until every result is back.
    directed_words();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    random_words(300, 32'd65536);

    // 2D with zero scale and the smallest nonzero reciprocal length.
    write_reg(csk_pkg::CFG_3D, 0);
    write_reg(csk_pkg::CFG_KSCALE, 0);
    write_reg(csk_pkg::CFG_INV_H, 1);
    directed_words();
    random_words(250, 1);

    // Extremes: saturating gradients in 3D.
    write_reg(csk_pkg::CFG_3D, 1);
    write_reg(csk_pkg::CFG_KSCALE, 32'hFFFF_FFFF);
    write_reg(csk_pkg::CFG_INV_H, 32'hFFFF_FFFF);
    directed_words();
    send_disp(1, 0, 0);
    send_disp(-1, 0, 0);
    send_disp(0, 1, -1);
    random_words(250, 32'hFFFF_FFFF);

    // Zero reciprocal length makes every pair sit at q = 0.
    write_reg(csk_pkg::CFG_INV_H, 0);
    send_disp(12345, -777, 32'h8000_0000);
    random_words(100, 0);

    // Random settings.
    for (int ph = 0; ph < 5; ph++) begin
      ih = $urandom >> $urandom_range(20, 8);
      if (ih == 0) ih = 1;
      write_reg(csk_pkg::CFG_INV_H, ih);
      write_reg(csk_pkg::CFG_KSCALE, $urandom >> $urandom_range(24));
      write_reg(csk_pkg::CFG_3D, $urandom_range(1));
      random_words(220, ih);
    end

    // Drain and give the verdict.
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (csk_pkg::LATENCY + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/csk_pkg.sv
rtl/cubic_spline_sph_kernel.sv
verif/cubic_spline_sph_kernel_checker.sv
verif/cubic_spline_sph_kernel_test.sv
